/* rtl/mffd_pkg.sv */
// Shared types and constants for the motor feedback frame decoder.
`timescale 1ns / 1ps

package mffd_pkg;

	// Field widths fixed by the frame and report formats.
	localparam int ID_W    = 11;
	localparam int BYTE_W  = 8;
	localparam int MASK_W  = 8;
	localparam int SLOT_W  = 3;
	localparam int KIND_W  = 2;
	localparam int POS_W   = 32;
	localparam int FIELD_W = 16;
	localparam int ANG_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Per-slot state widths.
	localparam int FC_W   = 4;
	localparam int RAW_W  = 17;
	localparam int TURN_W = 16;
	localparam int ZERO_W = 16;
	localparam int DIFF_W = 18;
	localparam int SUM_W  = 34;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_A_BASE_ID   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A_SLOT_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_BASE_ID   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B_SLOT_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_C_BASE_ID   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_C_SLOT_MASK = 3'd5;

	localparam logic [ID_W-1:0] A_BASE_ID_RESET = 11'd513;

	// Report kind codes.
	localparam logic [KIND_W-1:0] KIND_A     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_B     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_C     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd3;

	// Frame decode constants.
	localparam logic [ID_W-1:0]   ID_KIND_C      = 11'h000;
	localparam logic [BYTE_W-1:0] B_CMD_FEEDBACK = 8'hA1;
	localparam logic [BYTE_W-1:0] B_CMD_ANGLE    = 8'h92;

	// Unwrap thresholds and turn spans (as shift amounts).
	localparam logic [DIFF_W-1:0] HALF_A  = 18'd4096;
	localparam logic [DIFF_W-1:0] HALF_BC = 18'd32768;
	localparam int SPAN_A_SHIFT  = 13;
	localparam int SPAN_BC_SHIFT = 16;

	localparam logic [TURN_W-1:0] TURN_MAX = 16'h7FFF;
	localparam logic [TURN_W-1:0] TURN_MIN = 16'h8000;

	// Result of a slot lookup.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} slot_hit_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic capture;
		logic decode;
		logic load;
		logic commit;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic has_result;
		logic out_free;
	} sts_t;

endpackage

/* rtl/mffd_ctrl.sv */
// Sequencer for the motor feedback frame decoder: capture, decode, load, commit.
`timescale 1ns / 1ps

module mffd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           frame_valid,
	output logic           frame_stall,
	input  mffd_pkg::sts_t sts,
	output mffd_pkg::cmd_t cmd
);
	import mffd_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_LOAD   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// The frame port is open only while no frame is in work.
	assign frame_stall = (state_q != ST_IDLE);

	// Commands follow the state; a commit with a result waits for the output register.
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && frame_valid;
		cmd.decode  = (state_q == ST_DECODE);
		cmd.load    = (state_q == ST_LOAD);
		cmd.commit  = (state_q == ST_COMMIT) && (!sts.has_result || sts.out_free);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (frame_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (cmd.commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/mffd_dp.sv */
// Datapath of the motor feedback frame decoder: config, slot state, unwrap and report.
`timescale 1ns / 1ps

module mffd_dp #(
	parameter int SLOTS_PER_KIND      = 8,
	parameter int ZERO_CAPTURE_FRAMES = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mffd_pkg::cmd_t                    cmd,
	output mffd_pkg::sts_t                    sts,
	input  logic                              cfg_write,
	input  logic [mffd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mffd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [mffd_pkg::ID_W-1:0]         frame_id,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_0,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_1,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_2,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_3,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_4,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_5,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_6,
	input  logic [mffd_pkg::BYTE_W-1:0]       byte_7,
	output logic                              report_valid,
	input  logic                              report_stall,
	output logic [mffd_pkg::KIND_W-1:0]       report_kind,
	output logic [mffd_pkg::SLOT_W-1:0]       slot_index,
	output logic signed [mffd_pkg::POS_W-1:0] multi_turn_position,
	output logic signed [mffd_pkg::FIELD_W-1:0] velocity_raw,
	output logic signed [mffd_pkg::FIELD_W-1:0] current_raw,
	output logic [mffd_pkg::ANG_W-1:0]        absolute_angle
);
	import mffd_pkg::*;

	localparam int NUM_SLOTS = 3 * SLOTS_PER_KIND;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [FC_W-1:0] ZCF = FC_W'(ZERO_CAPTURE_FRAMES);

	// Slot lookup: key must lie in [base, base + SLOTS_PER_KIND) with its mask bit set.
	function automatic slot_hit_t find_slot(input logic [ID_W-1:0] key,
	                                        input logic [ID_W-1:0] base,
	                                        input logic [MASK_W-1:0] mask);
		slot_hit_t  r;
		logic [ID_W:0] diff;
		diff   = {1'b0, key} - {1'b0, base};
		r.slot = diff[SLOT_W-1:0];
		r.hit  = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(SLOTS_PER_KIND)) &&
		         mask[diff[SLOT_W-1:0]];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers.
	logic [ID_W-1:0]   a_base_q;
	logic [MASK_W-1:0] a_mask_q;
	logic [ID_W-1:0]   b_base_q;
	logic [MASK_W-1:0] b_mask_q;
	logic [BYTE_W-1:0] c_base_q;
	logic [MASK_W-1:0] c_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_base_q <= A_BASE_ID_RESET;
			a_mask_q <= '0;
			b_base_q <= '0;
			b_mask_q <= '0;
			c_base_q <= '0;
			c_mask_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_A_BASE_ID:   a_base_q <= cfg_data;
				CFG_A_SLOT_MASK: a_mask_q <= cfg_data[MASK_W-1:0];
				CFG_B_BASE_ID:   b_base_q <= cfg_data;
				CFG_B_SLOT_MASK: b_mask_q <= cfg_data[MASK_W-1:0];
				CFG_C_BASE_ID:   c_base_q <= cfg_data[BYTE_W-1:0];
				CFG_C_SLOT_MASK: c_mask_q <= cfg_data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Frame capture register.
	logic [ID_W-1:0]   frame_id_q;
	logic [BYTE_W-1:0] frm_byte_q [8];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_id_q    <= frame_id;
			frm_byte_q[0] <= byte_0;
			frm_byte_q[1] <= byte_1;
			frm_byte_q[2] <= byte_2;
			frm_byte_q[3] <= byte_3;
			frm_byte_q[4] <= byte_4;
			frm_byte_q[5] <= byte_5;
			frm_byte_q[6] <= byte_6;
			frm_byte_q[7] <= byte_7;
		end
	end

	// ---------------------------------------------------------------
	// Decode: kind A first, then kind B, then kind C on id zero.
	slot_hit_t          hit_a;
	slot_hit_t          hit_b;
	slot_hit_t          hit_c;
	logic               dec_hit;
	logic               dec_upd;
	logic [KIND_W-1:0]  dec_kind;
	logic [SLOT_W-1:0]  dec_slot;
	logic [IDX_W-1:0]   dec_idx;
	logic [FIELD_W-1:0] dec_vel;
	logic [FIELD_W-1:0] dec_cur;
	logic [ANG_W-1:0]   dec_ang;

	assign hit_a = find_slot(frame_id_q, a_base_q, a_mask_q);
	assign hit_b = find_slot(frame_id_q, b_base_q, b_mask_q);
	assign hit_c = find_slot({3'b000, frm_byte_q[0]}, {3'b000, c_base_q}, c_mask_q);

	always_comb begin
		dec_hit  = 1'b0;
		dec_upd  = 1'b0;
		dec_kind = KIND_A;
		dec_slot = '0;
		dec_idx  = '0;
		dec_vel  = '0;
		dec_cur  = '0;
		dec_ang  = '0;
		if (hit_a.hit) begin
			dec_hit  = 1'b1;
			dec_upd  = 1'b1;
			dec_kind = KIND_A;
			dec_slot = hit_a.slot;
			dec_idx  = IDX_W'(hit_a.slot);
			dec_vel  = {frm_byte_q[2], frm_byte_q[3]};
			dec_cur  = {frm_byte_q[4], frm_byte_q[5]};
		end else if (hit_b.hit) begin
			dec_slot = hit_b.slot;
			if (frm_byte_q[0] == B_CMD_FEEDBACK) begin
				dec_hit  = 1'b1;
				dec_upd  = 1'b1;
				dec_kind = KIND_B;
				dec_idx  = IDX_W'(SLOTS_PER_KIND) + IDX_W'(hit_b.slot);
				dec_vel  = {frm_byte_q[5], frm_byte_q[4]};
				dec_cur  = {frm_byte_q[3], frm_byte_q[2]};
			end else if (frm_byte_q[0] == B_CMD_ANGLE) begin
				dec_hit  = 1'b1;
				dec_kind = KIND_ANGLE;
				dec_ang  = {frm_byte_q[7], frm_byte_q[3], frm_byte_q[2], frm_byte_q[1]};
			end
		end else if ((frame_id_q == ID_KIND_C) && hit_c.hit) begin
			dec_hit  = 1'b1;
			dec_upd  = 1'b1;
			dec_kind = KIND_C;
			dec_slot = hit_c.slot;
			dec_idx  = IDX_W'(2 * SLOTS_PER_KIND) + IDX_W'(hit_c.slot);
			dec_vel  = {4'b0000, frm_byte_q[3], frm_byte_q[4][7:4]};
			dec_cur  = {4'b0000, frm_byte_q[4][3:0], frm_byte_q[5]};
		end
	end

	logic               hit_q;
	logic               upd_q;
	logic [KIND_W-1:0]  kind_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FIELD_W-1:0] vel_q;
	logic [FIELD_W-1:0] cur_q;
	logic [ANG_W-1:0]   ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			upd_q <= 1'b0;
		end else if (cmd.decode) begin
			hit_q <= dec_hit;
			upd_q <= dec_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			kind_q <= dec_kind;
			slot_q <= dec_slot;
			idx_q  <= dec_idx;
			vel_q  <= dec_vel;
			cur_q  <= dec_cur;
			ang_q  <= dec_ang;
		end
	end

	// ---------------------------------------------------------------
	// Per-slot state, cleared by reset.
	logic [FC_W-1:0]   frame_count_q [NUM_SLOTS];
	logic [RAW_W-1:0]  last_raw_q    [NUM_SLOTS];
	logic [TURN_W-1:0] turn_count_q  [NUM_SLOTS];
	logic [ZERO_W-1:0] zero_value_q  [NUM_SLOTS];

	// ---------------------------------------------------------------
	// Load: read the slot and work out the unwrap and the new state.
	logic [FC_W-1:0]   rd_fc;
	logic [RAW_W-1:0]  rd_last;
	logic [TURN_W-1:0] rd_turn;
	logic [ZERO_W-1:0] rd_zero;
	logic              capture_zero;
	logic              first_frame;
	logic [ZERO_W-1:0] raw_a;
	logic [ZERO_W-1:0] enc_b;
	logic [RAW_W-1:0]  raw_new;
	logic [ZERO_W-1:0] zero_new;
	logic [DIFF_W-1:0] base_new;
	logic [DIFF_W-1:0] half;
	logic [DIFF_W-1:0] delta;
	logic [TURN_W-1:0] turn_new;
	logic [FC_W-1:0]   fc_new;

	assign rd_fc   = frame_count_q[idx_q];
	assign rd_last = last_raw_q[idx_q];
	assign rd_turn = turn_count_q[idx_q];
	assign rd_zero = zero_value_q[idx_q];

	assign capture_zero = (rd_fc < ZCF);
	assign first_frame  = (rd_fc == '0);
	assign raw_a        = {frm_byte_q[0], frm_byte_q[1]};
	assign enc_b        = {frm_byte_q[7], frm_byte_q[6]};

	// Raw value, captured zero and the zero-corrected base of the position.
	always_comb begin
		case (kind_q)
			KIND_A: begin
				raw_new  = {1'b0, raw_a};
				zero_new = capture_zero ? raw_a : rd_zero;
				base_new = capture_zero ? '0 : ({2'b00, raw_a} - {2'b00, rd_zero});
				half     = HALF_A;
			end
			KIND_B: begin
				raw_new  = first_frame ? '0 : ({1'b0, enc_b} - {1'b0, rd_zero});
				zero_new = first_frame ? enc_b : rd_zero;
				base_new = {raw_new[RAW_W-1], raw_new};
				half     = HALF_BC;
			end
			default: begin
				raw_new  = {1'b0, frm_byte_q[1], frm_byte_q[2]};
				zero_new = rd_zero;
				base_new = {raw_new[RAW_W-1], raw_new};
				half     = HALF_BC;
			end
		endcase
	end

	// Unwrap against the previous raw value from the second frame on.
	assign delta = {raw_new[RAW_W-1], raw_new} - {rd_last[RAW_W-1], rd_last};

	always_comb begin
		turn_new = rd_turn;
		if (!first_frame) begin
			if ($signed(delta) > $signed(half)) begin
				if (rd_turn != TURN_MIN) begin
					turn_new = rd_turn - 1'b1;
				end
			end else if ($signed(delta) < -$signed(half)) begin
				if (rd_turn != TURN_MAX) begin
					turn_new = rd_turn + 1'b1;
				end
			end
		end
	end

	assign fc_new = capture_zero ? rd_fc + 1'b1 : rd_fc;

	logic [FC_W-1:0]   fc_wr_q;
	logic [RAW_W-1:0]  raw_wr_q;
	logic [TURN_W-1:0] turn_wr_q;
	logic [ZERO_W-1:0] zero_wr_q;
	logic [DIFF_W-1:0] base_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fc_wr_q   <= fc_new;
			raw_wr_q  <= raw_new;
			turn_wr_q <= turn_new;
			zero_wr_q <= zero_new;
			base_q    <= base_new;
		end
	end

	// Write the slot back at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				frame_count_q[i] <= '0;
				last_raw_q[i]    <= '0;
				turn_count_q[i]  <= '0;
				zero_value_q[i]  <= '0;
			end
		end else if (cmd.commit && upd_q) begin
			frame_count_q[idx_q] <= fc_wr_q;
			last_raw_q[idx_q]    <= raw_wr_q;
			turn_count_q[idx_q]  <= turn_wr_q;
			zero_value_q[idx_q]  <= zero_wr_q;
		end
	end

	// ---------------------------------------------------------------
	// Commit: base plus turns times span, saturated to 32 bits; zero for an angle report.
	logic [SUM_W-1:0] turn_ext;
	logic [SUM_W-1:0] turn_span;
	logic [SUM_W-1:0] pos_sum;
	logic [POS_W-1:0] pos_sat;

	assign turn_ext  = {{(SUM_W - TURN_W){turn_wr_q[TURN_W-1]}}, turn_wr_q};
	assign turn_span = (kind_q == KIND_A) ? (turn_ext << SPAN_A_SHIFT) :
	                                        (turn_ext << SPAN_BC_SHIFT);
	assign pos_sum   = {{(SUM_W - DIFF_W){base_q[DIFF_W-1]}}, base_q} + turn_span;

	always_comb begin
		if (kind_q == KIND_ANGLE) begin
			pos_sat = '0;
		end else if (pos_sum[SUM_W-1:POS_W-1] == '0 ||
		             pos_sum[SUM_W-1:POS_W-1] == '1) begin
			pos_sat = pos_sum[POS_W-1:0];
		end else if (pos_sum[SUM_W-1]) begin
			pos_sat = {1'b1, {(POS_W - 1){1'b0}}};
		end else begin
			pos_sat = {1'b0, {(POS_W - 1){1'b1}}};
		end
	end

	// ---------------------------------------------------------------
	// Output register; a waiting beat leaves the sequencer free until the next commit.
	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [FIELD_W-1:0] out_vel_q;
	logic [FIELD_W-1:0] out_cur_q;
	logic [ANG_W-1:0]   out_ang_q;
	logic               load_out;

	assign load_out = cmd.commit && hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!report_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q <= kind_q;
			out_slot_q <= slot_q;
			out_pos_q  <= pos_sat;
			out_vel_q  <= vel_q;
			out_cur_q  <= cur_q;
			out_ang_q  <= ang_q;
		end
	end

	assign sts.has_result = hit_q;
	assign sts.out_free   = !out_valid_q || !report_stall;

	assign report_valid        = out_valid_q;
	assign report_kind         = out_kind_q;
	assign slot_index          = out_slot_q;
	assign multi_turn_position = $signed(out_pos_q);
	assign velocity_raw        = $signed(out_vel_q);
	assign current_raw         = $signed(out_cur_q);
	assign absolute_angle      = out_ang_q;

endmodule

/* rtl/motor_feedback_frame_decoder_top.sv */
// Top level of the motor feedback frame decoder.
// Each frame passes the capture, decode, load and commit steps before its report beat is
// registered; the four-state sequencer takes no new frame until the read-modify-write of
// one slot is done, and a commit with a result waits while the output holds a stalled beat.
// Reset: asynchronous, active low; registers return to their reset values and all slot
// state clears to zero at once, so no clearing pass comes before frames are taken.
`timescale 1ns / 1ps

module motor_feedback_frame_decoder_top #(
	parameter int SLOTS_PER_KIND      = 8,
	parameter int ZERO_CAPTURE_FRAMES = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mffd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mffd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                frame_valid,
	output logic                                frame_stall,
	input  logic [mffd_pkg::ID_W-1:0]           frame_id,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_0,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_1,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_2,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_3,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_4,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_5,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_6,
	input  logic [mffd_pkg::BYTE_W-1:0]         byte_7,
	output logic                                report_valid,
	input  logic                                report_stall,
	output logic [mffd_pkg::KIND_W-1:0]         report_kind,
	output logic [mffd_pkg::SLOT_W-1:0]         slot_index,
	output logic signed [mffd_pkg::POS_W-1:0]   multi_turn_position,
	output logic signed [mffd_pkg::FIELD_W-1:0] velocity_raw,
	output logic signed [mffd_pkg::FIELD_W-1:0] current_raw,
	output logic [mffd_pkg::ANG_W-1:0]          absolute_angle
);
	import mffd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	mffd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// Datapath with configuration, slot state and output register.
	mffd_dp #(
		.SLOTS_PER_KIND      (SLOTS_PER_KIND),
		.ZERO_CAPTURE_FRAMES (ZERO_CAPTURE_FRAMES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_write           (cfg_write),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.frame_id            (frame_id),
		.byte_0              (byte_0),
		.byte_1              (byte_1),
		.byte_2              (byte_2),
		.byte_3              (byte_3),
		.byte_4              (byte_4),
		.byte_5              (byte_5),
		.byte_6              (byte_6),
		.byte_7              (byte_7),
		.report_valid        (report_valid),
		.report_stall        (report_stall),
		.report_kind         (report_kind),
		.slot_index          (slot_index),
		.multi_turn_position (multi_turn_position),
		.velocity_raw        (velocity_raw),
		.current_raw         (current_raw),
		.absolute_angle      (absolute_angle)
	);

endmodule

/* rtl/mffd_checker.sv */
// Port-level checker for the motor feedback frame decoder, bound to the top level.
`timescale 1ns / 1ps

module mffd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                frame_valid,
	input logic                                frame_stall,
	input logic                                report_valid,
	input logic                                report_stall,
	input logic [mffd_pkg::KIND_W-1:0]         report_kind,
	input logic [mffd_pkg::SLOT_W-1:0]         slot_index,
	input logic signed [mffd_pkg::POS_W-1:0]   multi_turn_position,
	input logic signed [mffd_pkg::FIELD_W-1:0] velocity_raw,
	input logic signed [mffd_pkg::FIELD_W-1:0] current_raw,
	input logic [mffd_pkg::ANG_W-1:0]          absolute_angle
);
	import mffd_pkg::*;

	// A frame in work closes the frame port for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_stall) |=> frame_stall)
		else $error("frame port open right after a frame beat");

	// A stalled report beat holds its kind, slot, position and angle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report_stall) |=> (report_valid && $stable(report_kind) &&
		 $stable(slot_index) && $stable(multi_turn_position) && $stable(absolute_angle)))
		else $error("stalled report beat changed");

	// An angle report carries no position, velocity or current.
	assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report_kind == KIND_ANGLE) |->
		(multi_turn_position == '0 && velocity_raw == '0 && current_raw == '0))
		else $error("angle report with nonzero feedback fields");

	// Only an angle report carries an absolute angle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report_kind != KIND_ANGLE) |-> (absolute_angle == '0))
		else $error("absolute angle set outside an angle report");

	// Kind C fields are twelve bits wide.
	assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report_kind == KIND_C) |->
		(velocity_raw[15:12] == 4'd0 && current_raw[15:12] == 4'd0))
		else $error("kind C field wider than twelve bits");

endmodule

bind motor_feedback_frame_decoder_top mffd_checker u_mffd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.frame_valid         (frame_valid),
	.frame_stall         (frame_stall),
	.report_valid        (report_valid),
	.report_stall        (report_stall),
	.report_kind         (report_kind),
	.slot_index          (slot_index),
	.multi_turn_position (multi_turn_position),
	.velocity_raw        (velocity_raw),
	.current_raw         (current_raw),
	.absolute_angle      (absolute_angle)
);
